FILE: hw/rtl/cfe_pkg.sv
`timescale 1ns / 1ps

package cfe_pkg;

   // input word kinds
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   // result word kinds
   localparam logic [1:0] OUT_TX     = 2'd0;
   localparam logic [1:0] OUT_DATA   = 2'd1;
   localparam logic [1:0] OUT_STATUS = 2'd2;

   // status codes
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_HEADER   = 4'd1;
   localparam logic [3:0] ST_LENGTH   = 4'd2;
   localparam logic [3:0] ST_SEQ      = 4'd3;
   localparam logic [3:0] ST_TYPE     = 4'd4;
   localparam logic [3:0] ST_CHECKSUM = 4'd5;
   localparam logic [3:0] ST_TRAILER  = 4'd6;
   localparam logic [3:0] ST_TIMEOUT  = 4'd7;
   localparam logic [3:0] ST_BUSY     = 4'd8;

   // frame bytes
   localparam logic [7:0] SYNC_START = 8'hFC;
   localparam logic [7:0] SYNC_HEAD  = 8'hFD;
   localparam logic [7:0] SYNC_TAIL  = 8'hFE;
   localparam logic [7:0] TX_LEN     = 8'h0B;
   localparam logic [7:0] RX_LEN     = 8'h19;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam int STORE_DEPTH = 22;
   localparam int STORE_AW    = 5;
   localparam int QUEUE_DEPTH_DEF = 2;

   // transmit frame positions
   localparam logic [3:0] FR_SEQ      = 4'd3;
   localparam logic [3:0] FR_TYPE     = 4'd4;
   localparam logic [3:0] FR_PAY      = 4'd5;
   localparam logic [3:0] FR_SUM_LAST = 4'd12;
   localparam logic [3:0] FR_CSUM     = 4'd13;
   localparam logic [3:0] FR_TAIL0    = 4'd14;
   localparam logic [3:0] FR_LAST     = 4'd15;

   // receive frame positions
   localparam logic [4:0] RX_HEAD0     = 5'd0;
   localparam logic [4:0] RX_HEAD1     = 5'd1;
   localparam logic [4:0] RX_LENPOS    = 5'd2;
   localparam logic [4:0] RX_SEQPOS    = 5'd3;
   localparam logic [4:0] RX_TYPEPOS   = 5'd4;
   localparam logic [4:0] RX_DATA0     = 5'd5;
   localparam logic [4:0] RX_DATA_LAST = 5'd26;
   localparam logic [4:0] RX_CSUMPOS   = 5'd27;
   localparam logic [4:0] RX_TAIL0     = 5'd28;
   localparam logic [4:0] RX_LAST      = 5'd29;

   typedef enum logic [1:0] {
      JOB_FRAME,
      JOB_RESP,
      JOB_STATUS
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   seq;
      logic [7:0]   ctype;
      logic [63:0]  payload;
      logic [4:0]   rlen;
      logic [3:0]   status;
   } job_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FRAME,
      BK_PRIME,
      BK_DATA,
      BK_STATUS
   } back_state_type;

endpackage

FILE: hw/rtl/cfe_queue.sv
`timescale 1ns / 1ps

module cfe_queue #(
   parameter int DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cfe_pkg::job_type        job_wr,
   input  logic                    pop,
   output cfe_pkg::job_type        job_head,
   output cfe_pkg::queue_stat_type stat
);
   import cfe_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   job_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   always_comb begin
      stat.full  = (cnt_ff == CNT_FULL);
      stat.empty = (cnt_ff == '0);
      do_push    = push & ~stat.full;
      do_pop     = pop & ~stat.empty;
      job_head   = entry_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      cnt_in     = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_wr;
      end
   end

endmodule

FILE: hw/rtl/cfe_front.sv
`timescale 1ns / 1ps

module cfe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_cmd_type,
   input  logic [63:0]             req_payload,
   input  logic [3:0]              req_payload_len,
   input  logic [4:0]              req_resp_len,
   input  logic [7:0]              req_rx_byte,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  cfe_pkg::queue_stat_type q_stat,
   input  logic                    resp_done,
   output logic                    push,
   output cfe_pkg::job_type        job_wr,
   output cfe_pkg::store_wr_type   store_wr,
   output logic                    hold
);
   import cfe_pkg::*;

   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  seq_ff, seq_in;
   logic        await_ff, await_in;
   logic [7:0]  ptype_ff, ptype_in;
   logic [4:0]  prlen_ff, prlen_in;
   logic [4:0]  rxcnt_ff, rxcnt_in;
   logic [7:0]  rxsum_ff, rxsum_in;
   logic [3:0]  ferr_ff, ferr_in;
   logic [15:0] tick_ff, tick_in;
   logic        hold_ff, hold_in;

   logic        accept;
   logic [63:0] pay_masked;
   logic [4:0]  rlen_clip;
   logic [3:0]  err_now;
   logic [3:0]  err_sel;
   logic [15:0] tick_next;

   assign req_ready = ~q_stat.full & ~hold_ff;
   assign hold      = hold_ff;
   assign accept    = req_valid & req_ready;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pay_masked[i*8 +: 8] = (4'(i) < req_payload_len) ? req_payload[i*8 +: 8] : 8'h00;
      end
      rlen_clip = (req_resp_len > 5'(STORE_DEPTH)) ? 5'(STORE_DEPTH) : req_resp_len;
      tick_next = (tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;

      err_now = ST_OK;
      case (rxcnt_ff)
         RX_HEAD0:   if (req_rx_byte != SYNC_START) err_now = ST_HEADER;
         RX_HEAD1:   if (req_rx_byte != SYNC_HEAD) err_now = ST_HEADER;
         RX_LENPOS:  if (req_rx_byte != RX_LEN) err_now = ST_LENGTH;
         RX_SEQPOS:  if (req_rx_byte != seq_ff) err_now = ST_SEQ;
         RX_TYPEPOS: if (req_rx_byte != ptype_ff) err_now = ST_TYPE;
         RX_CSUMPOS: if (req_rx_byte != rxsum_ff) err_now = ST_CHECKSUM;
         RX_TAIL0:   if (req_rx_byte != SYNC_START) err_now = ST_TRAILER;
         RX_LAST:    if (req_rx_byte != SYNC_TAIL) err_now = ST_TRAILER;
         default:    err_now = ST_OK;
      endcase
      err_sel = (ferr_ff != ST_OK) ? ferr_ff : err_now;
   end

   always_comb begin
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      seq_in     = seq_ff;
      await_in   = await_ff;
      ptype_in   = ptype_ff;
      prlen_in   = prlen_ff;
      rxcnt_in   = rxcnt_ff;
      rxsum_in   = rxsum_ff;
      ferr_in    = ferr_ff;
      tick_in    = tick_ff;
      hold_in    = hold_ff & ~resp_done;
      push       = 1'b0;
      job_wr     = '0;
      store_wr   = '0;

      if (accept) begin
         case (req_kind)
            KIND_CMD: begin
               push = 1'b1;
               if (await_ff) begin
                  job_wr.kind   = JOB_STATUS;
                  job_wr.status = ST_BUSY;
               end else begin
                  seq_in         = seq_ff + 8'd1;
                  job_wr.kind    = JOB_FRAME;
                  job_wr.seq     = seq_ff + 8'd1;
                  job_wr.ctype   = req_cmd_type;
                  job_wr.payload = pay_masked;
                  await_in       = 1'b1;
                  ptype_in       = req_cmd_type;
                  prlen_in       = rlen_clip;
                  rxcnt_in       = '0;
                  rxsum_in       = '0;
                  ferr_in        = ST_OK;
                  tick_in        = '0;
               end
            end
            KIND_BYTE: begin
               if (await_ff) begin
                  if (rxcnt_ff >= RX_LENPOS && rxcnt_ff <= RX_DATA_LAST) begin
                     rxsum_in = rxsum_ff + req_rx_byte;
                  end
                  if (rxcnt_ff >= RX_DATA0 && rxcnt_ff <= RX_DATA_LAST) begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = rxcnt_ff - RX_DATA0;
                     store_wr.data = req_rx_byte;
                  end
                  ferr_in = err_sel;
                  if (rxcnt_ff != RX_LAST) begin
                     rxcnt_in = rxcnt_ff + 5'd1;
                  end else begin
                     await_in      = 1'b0;
                     rxcnt_in      = '0;
                     push          = 1'b1;
                     job_wr.status = err_sel;
                     job_wr.rlen   = prlen_ff;
                     if (err_sel == ST_OK && prlen_ff != '0) begin
                        job_wr.kind = JOB_RESP;
                        hold_in     = 1'b1;
                     end else begin
                        job_wr.kind = JOB_STATUS;
                     end
                  end
               end
            end
            KIND_TICK: begin
               if (await_ff) begin
                  tick_in = tick_next;
                  if (tick_next >= timeout_ff) begin
                     await_in      = 1'b0;
                     push          = 1'b1;
                     job_wr.kind   = JOB_STATUS;
                     job_wr.status = ST_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         seq_ff     <= '0;
         await_ff   <= 1'b0;
         ptype_ff   <= '0;
         prlen_ff   <= '0;
         rxcnt_ff   <= '0;
         rxsum_ff   <= '0;
         ferr_ff    <= ST_OK;
         tick_ff    <= '0;
         hold_ff    <= 1'b0;
      end else begin
         timeout_ff <= timeout_in;
         seq_ff     <= seq_in;
         await_ff   <= await_in;
         ptype_ff   <= ptype_in;
         prlen_ff   <= prlen_in;
         rxcnt_ff   <= rxcnt_in;
         rxsum_ff   <= rxsum_in;
         ferr_ff    <= ferr_in;
         tick_ff    <= tick_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

FILE: hw/rtl/cfe_back.sv
`timescale 1ns / 1ps

module cfe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cfe_pkg::job_type        job_head,
   input  cfe_pkg::queue_stat_type q_stat,
   output logic                    pop,
   input  cfe_pkg::store_wr_type   store_wr,
   output logic                    resp_done,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_out_kind,
   output logic [7:0]              rsp_byte_value,
   output logic [3:0]              rsp_status,
   output logic                    rsp_last
);
   import cfe_pkg::*;

   logic [7:0]          store_mem [STORE_DEPTH];
   logic [7:0]          rd_data_ff;
   logic [STORE_AW-1:0] rd_addr;

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [4:0]     idx_ff, idx_in;
   logic [7:0]     sum_ff, sum_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     kind_ff, kind_in;
   logic [7:0]     byte_ff, byte_in;
   logic [3:0]     status_ff, status_in;
   logic           last_ff, last_in;

   logic           load;
   logic           out_load;
   logic [3:0]     fpos;
   logic [3:0]     poff;
   logic [7:0]     fbyte;

   assign load = ~rsp_valid_ff | rsp_ready;

   // transmit frame byte at the current position
   always_comb begin
      fpos = idx_ff[3:0];
      poff = fpos - FR_PAY;
      case (fpos)
         4'd0:     fbyte = SYNC_START;
         4'd1:     fbyte = SYNC_HEAD;
         4'd2:     fbyte = TX_LEN;
         FR_SEQ:   fbyte = job_ff.seq;
         FR_TYPE:  fbyte = job_ff.ctype;
         FR_CSUM:  fbyte = sum_ff;
         FR_TAIL0: fbyte = SYNC_START;
         FR_LAST:  fbyte = SYNC_TAIL;
         default:  fbyte = job_ff.payload[{poff[2:0], 3'b000} +: 8];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               case (job_head.kind)
                  JOB_FRAME: state_in = BK_FRAME;
                  JOB_RESP:  state_in = BK_PRIME;
                  default:   state_in = BK_STATUS;
               endcase
            end
         end
         BK_FRAME: if (load && fpos == FR_LAST) state_in = BK_IDLE;
         BK_PRIME: state_in = BK_DATA;
         BK_DATA:  if (load && idx_ff == job_ff.rlen - 5'd1) state_in = BK_STATUS;
         BK_STATUS: if (load) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      resp_done = 1'b0;
      job_in    = job_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      rd_addr   = '0;
      out_load  = 1'b0;
      kind_in   = OUT_TX;
      byte_in   = 8'h00;
      status_in = ST_OK;
      last_in   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               job_in = job_head;
               idx_in = '0;
               sum_in = '0;
            end
         end
         BK_FRAME: begin
            if (load) begin
               out_load = 1'b1;
               byte_in  = fbyte;
               last_in  = (fpos == FR_LAST);
               idx_in   = idx_ff + 5'd1;
               if (fpos >= 4'd2 && fpos <= FR_SUM_LAST) begin
                  sum_in = sum_ff + fbyte;
               end
            end
         end
         BK_PRIME: begin
            rd_addr = '0;
         end
         BK_DATA: begin
            rd_addr = idx_ff;
            if (load) begin
               out_load = 1'b1;
               kind_in  = OUT_DATA;
               byte_in  = rd_data_ff;
               idx_in   = idx_ff + 5'd1;
               if (idx_ff + 5'd1 < job_ff.rlen) begin
                  rd_addr = idx_ff + 5'd1;
               end
            end
         end
         BK_STATUS: begin
            if (load) begin
               out_load  = 1'b1;
               kind_in   = OUT_STATUS;
               status_in = job_ff.status;
               last_in   = 1'b1;
               resp_done = (job_ff.kind == JOB_RESP);
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load ? out_load : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      if (out_load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = kind_ff;
   assign rsp_byte_value = byte_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: hw/rtl/command_frame_exchanger.sv
// Channel   Ports   Flow          Word
// req       req_*   valid/ready   command, received byte or time tick
// rsp       rsp_*   valid/ready   transmit byte, response data byte or status
// csr       csr_*   write only    timeout_ticks, 16 bits
//
// Front takes one input word per cycle while the job queue has room and no hold.
// Back drains one job at a time: it takes the job from the queue, primes the
// store read for a response, then issues one result word per cycle while
// rsp_ready allows. A command gives 16 transmit bytes.
// After a good response with data, input stalls until its status word is issued.
// Synchronous active-high reset; no clearing pass.
`timescale 1ns / 1ps

module command_frame_exchanger #(
   parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_cmd_type,
   input  logic [63:0] req_payload,
   input  logic [3:0]  req_payload_len,
   input  logic [4:0]  req_resp_len,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [3:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import cfe_pkg::*;

   queue_stat_type q_stat;
   job_type        job_wr;
   job_type        job_head;
   store_wr_type   store_wr;
   logic           push;
   logic           pop;
   logic           resp_done;
   logic           hold;

   cfe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_cmd_type    (req_cmd_type),
      .req_payload     (req_payload),
      .req_payload_len (req_payload_len),
      .req_resp_len    (req_resp_len),
      .req_rx_byte     (req_rx_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_stat          (q_stat),
      .resp_done       (resp_done),
      .push            (push),
      .job_wr          (job_wr),
      .store_wr        (store_wr),
      .hold            (hold)
   );

   cfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .job_wr   (job_wr),
      .pop      (pop),
      .job_head (job_head),
      .stat     (q_stat)
   );

   cfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_head       (job_head),
      .q_stat         (q_stat),
      .pop            (pop),
      .store_wr       (store_wr),
      .resp_done      (resp_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("job queue underflow");

   a_done_in_hold: assert property (@(posedge clock) disable iff (reset)
      resp_done |-> hold)
      else $error("response drained without a held front");

   a_store_quiet: assert property (@(posedge clock) disable iff (reset)
      hold |-> !store_wr.en)
      else $error("response store written while being read");
`endif

endmodule

FILE: test/command_frame_exchanger_tb.sv
`timescale 1ns / 1ps

module command_frame_exchanger_tb;
   import cfe_pkg::*;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_WORDS = 35;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [3:0] status;
      logic       last;
   } result_word_type;

   class frame_scoreboard;
      logic [15:0] timeout_ticks = TIMEOUT_RESET;
      logic [7:0] seq_num = '0;
      bit awaiting = 1'b0;
      logic [7:0] pending_type = '0;
      logic [4:0] pending_len = '0;
      logic [4:0] rx_pos = '0;
      logic [7:0] rx_sum = '0;
      logic [3:0] first_err = ST_OK;
      logic [15:0] tick_count = '0;
      logic [7:0] data_store [STORE_DEPTH];
      result_word_type expected[$];
      int errors = 0;

      function void push(logic [1:0] k, logic [7:0] v, logic [3:0] s, logic l);
         result_word_type w;
         w.kind = k;
         w.value = v;
         w.status = s;
         w.last = l;
         expected.push_back(w);
      endfunction

      function void flag_error(bit bad, logic [3:0] code);
         if (bad && first_err == ST_OK) first_err = code;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // returns 1 when the word has any effect on the block
      function bit note_word(logic [1:0] kind, logic [7:0] ctype, logic [63:0] pay,
                             logic [3:0] plen, logic [4:0] rlen, logic [7:0] rx);
         logic [7:0] frame [16];
         logic [7:0] sum;
         int n;
         int i;
         if (kind == KIND_CMD) begin
            if (awaiting) begin
               push(OUT_STATUS, 8'h00, ST_BUSY, 1'b1);
               return 1'b1;
            end
            n = (plen > 8) ? 8 : plen;
            seq_num = seq_num + 8'd1;
            frame[0] = SYNC_START;
            frame[1] = SYNC_HEAD;
            frame[2] = TX_LEN;
            frame[3] = seq_num;
            frame[4] = ctype;
            for (i = 0; i < 8; i++) frame[5 + i] = (i < n) ? pay[8 * i +: 8] : 8'h00;
            sum = '0;
            for (i = 2; i <= 12; i++) sum = sum + frame[i];
            frame[13] = sum;
            frame[14] = SYNC_START;
            frame[15] = SYNC_TAIL;
            for (i = 0; i < 16; i++) push(OUT_TX, frame[i], ST_OK, i == 15);
            awaiting = 1'b1;
            pending_type = ctype;
            pending_len = (rlen > STORE_DEPTH) ? 5'(STORE_DEPTH) : rlen;
            rx_pos = '0;
            rx_sum = '0;
            first_err = ST_OK;
            tick_count = '0;
            return 1'b1;
         end
         if (!awaiting || kind == KIND_NONE) return 1'b0;
         if (kind == KIND_TICK) begin
            if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
            if (tick_count >= timeout_ticks) begin
               awaiting = 1'b0;
               push(OUT_STATUS, 8'h00, ST_TIMEOUT, 1'b1);
            end
            return 1'b1;
         end
         if (rx_pos >= RX_LENPOS && rx_pos <= RX_DATA_LAST) rx_sum = rx_sum + rx;
         if (rx_pos >= RX_DATA0 && rx_pos <= RX_DATA_LAST) data_store[rx_pos - RX_DATA0] = rx;
         case (rx_pos)
            RX_HEAD0:   flag_error(rx != SYNC_START, ST_HEADER);
            RX_HEAD1:   flag_error(rx != SYNC_HEAD, ST_HEADER);
            RX_LENPOS:  flag_error(rx != RX_LEN, ST_LENGTH);
            RX_SEQPOS:  flag_error(rx != seq_num, ST_SEQ);
            RX_TYPEPOS: flag_error(rx != pending_type, ST_TYPE);
            RX_CSUMPOS: flag_error(rx != rx_sum, ST_CHECKSUM);
            RX_TAIL0:   flag_error(rx != SYNC_START, ST_TRAILER);
            RX_LAST:    flag_error(rx != SYNC_TAIL, ST_TRAILER);
            default: ;
         endcase
         if (rx_pos != RX_LAST) begin
            rx_pos = rx_pos + 5'd1;
            return 1'b1;
         end
         awaiting = 1'b0;
         rx_pos = '0;
         if (first_err == ST_OK) begin
            for (i = 0; i < pending_len; i++) push(OUT_DATA, data_store[i], ST_OK, 1'b0);
         end
         push(OUT_STATUS, 8'h00, first_err, 1'b1);
         return 1'b1;
      endfunction

      function void check_result(logic [1:0] k, logic [7:0] v, logic [3:0] s, logic l);
         result_word_type w;
         if (expected.size() == 0) begin
            $error("unexpected word: out_kind %0d byte_value %0h status %0d last %0d",
                   k, v, s, l);
            errors++;
            return;
         end
         w = expected.pop_front();
         if (k !== w.kind) begin
            $error("out_kind: expected %0d, actual %0d", w.kind, k);
            errors++;
         end
         if (v !== w.value) begin
            $error("byte_value: expected %0h, actual %0h", w.value, v);
            errors++;
         end
         if (s !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, s);
            errors++;
         end
         if (l !== w.last) begin
            $error("last: expected %0d, actual %0d", w.last, l);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_cmd_type = '0;
   logic [63:0] req_payload = '0;
   logic [3:0]  req_payload_len = '0;
   logic [4:0]  req_resp_len = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_byte_value;
   logic [3:0]  rsp_status;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   frame_scoreboard sb = new;
   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int counted = 0;
   int ready_hold = 0;
   int quiet = 0;
   logic [15:0] phase_timeout [4] = '{16'd1, 16'd6, 16'd40, 16'hFFFF};

   command_frame_exchanger uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_cmd_type    (req_cmd_type),
      .req_payload     (req_payload),
      .req_payload_len (req_payload_len),
      .req_resp_len    (req_resp_len),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready && rx_idle && $urandom_range(0, 1) == 1) begin
         rsp_ready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_out_kind, rsp_byte_value, rsp_status, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] kind, input logic [7:0] ctype,
                            input logic [63:0] pay, input logic [3:0] plen,
                            input logic [4:0] rlen, input logic [7:0] rx);
      int gap;
      gap = tx_idle ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_cmd_type <= ctype;
      req_payload <= pay;
      req_payload_len <= plen;
      req_resp_len <= rlen;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sb.note_word(kind, ctype, pay, plen, rlen, rx)) counted++;
   endtask

   task automatic send_cmd(input logic [7:0] ctype, input logic [63:0] pay,
                           input logic [3:0] plen, input logic [4:0] rlen);
      send_word(KIND_CMD, ctype, pay, plen, rlen, 8'($urandom));
   endtask

   task automatic send_random_cmd();
      logic [3:0] plen;
      logic [4:0] rlen;
      plen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      rlen = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(23, 31)) : 5'($urandom_range(0, 22));
      send_cmd(8'($urandom), {$urandom, $urandom}, plen, rlen);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(KIND_BYTE, 8'($urandom), {$urandom, $urandom}, 4'($urandom),
                5'($urandom), b);
   endtask

   task automatic send_tick();
      send_word(KIND_TICK, 8'($urandom), {$urandom, $urandom}, 4'($urandom),
                5'($urandom), 8'($urandom));
   endtask

   // bad_pos < 0 sends a clean frame; data corruption shows up as a checksum error
   task automatic send_response(input int bad_pos, input bit mix_ticks);
      logic [7:0] frame [30];
      logic [7:0] sum;
      int i;
      frame[0] = SYNC_START;
      frame[1] = SYNC_HEAD;
      frame[2] = RX_LEN;
      frame[3] = sb.seq_num;
      frame[4] = sb.pending_type;
      for (i = 5; i < 27; i++) frame[i] = 8'($urandom);
      sum = '0;
      for (i = 2; i < 27; i++) sum = sum + frame[i];
      frame[27] = sum;
      frame[28] = SYNC_START;
      frame[29] = SYNC_TAIL;
      if (bad_pos >= 0) frame[bad_pos] = frame[bad_pos] ^ 8'($urandom_range(1, 255));
      for (i = 0; i < 30; i++) begin
         if (mix_ticks && $urandom_range(0, 5) == 0) send_tick();
         send_byte(frame[i]);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.timeout_ticks = v;
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int phase;
      int r;
      int n;
      int bad_list [2];
      bad_list = '{3, 27};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle words are dropped
      send_byte(8'hFF);
      send_tick();
      send_word(KIND_NONE, 8'hFF, '1, 4'hF, 5'h1F, 8'h00);
      // oversize lengths clamp, then a command while waiting is busy
      send_cmd(8'hFF, '1, 4'hF, 5'h1F);
      send_cmd(8'h00, '0, 4'd0, 5'd0);
      send_response(-1, 1'b0);
      send_cmd(8'h00, '0, 4'd0, 5'd0);
      send_response(-1, 1'b0);
      foreach (bad_list[i]) begin
         send_random_cmd();
         send_response(bad_list[i], 1'b0);
      end
      settle();
      // timeout, unused kind mixed in
      write_timeout(16'd3);
      send_random_cmd();
      send_word(KIND_NONE, 8'($urandom), '0, 4'd0, 5'd0, 8'hFF);
      tx_idle = 1'b0;
      while (sb.awaiting) send_tick();
      tx_idle = 1'b1;
      settle();

      for (phase = 0; phase < 4; phase++) begin
         write_timeout(phase_timeout[phase]);
         tx_idle = (phase != 1);
         rx_idle = (phase != 1);
         counted = 0;
         while (counted < PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               if (!sb.awaiting) send_random_cmd();
               send_response(-1, $urandom_range(0, 3) == 0);
            end else if (r < 72) begin
               if (!sb.awaiting) send_random_cmd();
               send_response($urandom_range(0, 29), 1'b0);
            end else if (r < 82) begin
               if (!sb.awaiting) send_random_cmd();
               n = 0;
               while (sb.awaiting && n < 50) begin
                  send_tick();
                  n++;
               end
            end else if (r < 90) begin
               send_random_cmd();
               send_random_cmd();
            end else begin
               repeat ($urandom_range(1, 6))
                  send_word(2'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom},
                            4'($urandom), 5'($urandom), 8'($urandom));
            end
         end
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_queue.sv
hw/rtl/cfe_front.sv
hw/rtl/cfe_back.sv
hw/rtl/command_frame_exchanger.sv
test/command_frame_exchanger_tb.sv
